FILE: design/scc_pkg.sv
// Shared types and codes for the sector cache tag and clock replacement engine.
package scc_pkg;

    localparam int MODE_W = 3;
    localparam int DEV_W  = 8;
    localparam int SEC_W  = 32;
    localparam int SLOT_W = 7;
    localparam int STAT_W = 2;
    localparam int TAG_W  = DEV_W + SEC_W;

    // Request modes as they arrive on the input queue
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MARK_RD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MARK_WR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd4;

    // Classified operations handed from the front end to the engine
    localparam logic [MODE_W-1:0] OP_ACQUIRE = 3'd0;
    localparam logic [MODE_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] OP_MARK_RD = 3'd2;
    localparam logic [MODE_W-1:0] OP_MARK_WR = 3'd3;
    localparam logic [MODE_W-1:0] OP_FLUSH   = 3'd4;
    localparam logic [MODE_W-1:0] OP_NOP     = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RETRY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_ALL_BUSY = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_DIRTY = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [DEV_W-1:0]  device;
        logic [SEC_W-1:0]  sector;
        logic [SLOT_W-1:0] slot;
        logic              slot_ok;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0] entry_slot;
        logic              hit;
        logic [STAT_W-1:0] status;
        logic              writeback;
        logic [DEV_W-1:0]  evict_device;
        logic [SEC_W-1:0]  evict_sector;
        logic              fill;
        logic              more_dirty;
    } t_res;

endpackage

FILE: design/sector_cache_clock_tags.sv
// Sector cache tag engine with clock replacement: front queue, engine and output stage.
// Each transaction is handled on its own by the engine after it leaves a two-deep input
// queue. Release, mark read, mark write, unknown modes and a flush with nothing dirty go
// from the execute state straight to the done state. A flush walks the dirty bits one
// entry per cycle and then reads the tag. An acquire streams the tag RAM through one
// comparator at one entry per cycle; on a miss with a free entry it steps the clock hand
// until it finds a victim, then reads the old tag and retags the victim. The one read
// port of the tag RAM and the one comparator keep this search serial. A finished result
// sits in an output register, so the next request is taken while it waits to be popped.
module sector_cache_clock_tags
    import scc_pkg::*;
#(
    parameter int ENTRIES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic [SEC_W-1:0]  i_sector,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              empty,
    input  logic              pop,
    output logic [SLOT_W-1:0] o_entry_slot,
    output logic              o_hit,
    output logic [STAT_W-1:0] o_status,
    output logic              o_writeback,
    output logic [DEV_W-1:0]  o_evict_device,
    output logic [SEC_W-1:0]  o_evict_sector,
    output logic              o_fill,
    output logic              o_more_dirty
);

    logic cmd_vld;
    t_cmd cmd;
    logic cmd_pop;
    logic eng_vld;
    t_res eng_res;
    logic eng_take;
    logic r_out_vld;
    t_res r_out;

    scc_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_device_id (i_device_id),
        .i_sector    (i_sector),
        .i_slot      (i_slot),
        .o_cmd_vld   (cmd_vld),
        .o_cmd       (cmd),
        .i_pop       (cmd_pop)
    );

    scc_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_res_vld  (eng_vld),
        .o_res      (eng_res),
        .i_res_take (eng_take)
    );

    // Take a result when the output register is free or being popped
    assign eng_take = eng_vld && (!r_out_vld || pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= eng_take || (r_out_vld && !pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_take) begin
            r_out <= eng_res;
        end
    end

    assign empty          = !r_out_vld;
    assign o_entry_slot   = r_out.entry_slot;
    assign o_hit          = r_out.hit;
    assign o_status       = r_out.status;
    assign o_writeback    = r_out.writeback;
    assign o_evict_device = r_out.evict_device;
    assign o_evict_sector = r_out.evict_sector;
    assign o_fill         = r_out.fill;
    assign o_more_dirty   = r_out.more_dirty;

endmodule

FILE: design/scc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module scc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/scc_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
module scc_front
    import scc_pkg::*;
#(
    parameter int ENTRIES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic [SEC_W-1:0]  i_sector,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_cmd_vld,
    output t_cmd              o_cmd,
    input  logic              i_pop
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [SLOT_W+IW:0] ENT_LIM = (SLOT_W + IW + 1)'(ENTRIES);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       cls;
    logic       push_ok;
    logic       pop_ok;

    // Classify the incoming request
    always_comb begin
        cls.device  = i_device_id;
        cls.sector  = i_sector;
        cls.slot    = i_slot;
        cls.slot_ok = ({{(IW + 1){1'b0}}, i_slot} < ENT_LIM);
        unique case (i_mode)
            MODE_ACQUIRE: cls.op = OP_ACQUIRE;
            MODE_RELEASE: cls.op = OP_RELEASE;
            MODE_MARK_RD: cls.op = OP_MARK_RD;
            MODE_MARK_WR: cls.op = OP_MARK_WR;
            MODE_FLUSH:   cls.op = OP_FLUSH;
            default:      cls.op = OP_NOP;
        endcase
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];
    assign push_ok   = i_push && !o_full;
    assign pop_ok    = i_pop && o_cmd_vld;

    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // Store the classified transaction
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

FILE: design/scc_engine.sv
// Back end: tag lookup, clock hand victim search, policy bits and flush scan.
module scc_engine
    import scc_pkg::*;
#(
    parameter int ENTRIES = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_vld,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_vld,
    output t_res o_res,
    input  logic i_res_take
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST     = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(ENTRIES);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_HAND  = 3'd3;
    localparam logic [2:0] S_VTAG  = 3'd4;
    localparam logic [2:0] S_FSCAN = 3'd5;
    localparam logic [2:0] S_FTAG  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]         r_state,     n_state;
    logic [ENTRIES-1:0] r_valid,     n_valid;
    logic [ENTRIES-1:0] r_dirty,     n_dirty;
    logic [ENTRIES-1:0] r_acc,       n_acc;
    logic [ENTRIES-1:0] r_busy,      n_busy;
    logic [CW-1:0]      r_busy_cnt,  n_busy_cnt;
    logic [CW-1:0]      r_dirty_cnt, n_dirty_cnt;
    logic [IW-1:0]      r_hand,      n_hand;
    logic [IW-1:0]      r_idx,       n_idx;
    logic [IW-1:0]      r_cmp_idx,   n_cmp_idx;
    logic               r_cmp_vld,   n_cmp_vld;
    logic [IW-1:0]      r_vic,       n_vic;
    logic               r_wb,        n_wb;
    t_cmd               r_cmd,       n_cmd;
    t_res               r_res,       n_res;

    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic               ram_we;
    logic [TAG_W-1:0]   ram_wdata;
    logic [TAG_W-1:0]   ram_rdata;

    logic [SLOT_W+IW-1:0] sl_ext;
    logic [SLOT_W+IW-1:0] cmp_ext;
    logic [SLOT_W+IW-1:0] hand_ext;
    logic [SLOT_W+IW-1:0] vic_ext;
    logic [IW-1:0]        s_idx;
    logic [IW-1:0]        hand_next;
    logic                 tag_hit;

    // Index and slot conversions between the port width and the entry index
    assign sl_ext    = {{IW{1'b0}}, r_cmd.slot};
    assign s_idx     = sl_ext[IW-1:0];
    assign cmp_ext   = {{SLOT_W{1'b0}}, r_cmp_idx};
    assign hand_ext  = {{SLOT_W{1'b0}}, r_hand};
    assign vic_ext   = {{SLOT_W{1'b0}}, r_vic};
    assign hand_next = (r_hand == LAST) ? '0 : r_hand + IW'(1);
    assign ram_wdata = {r_cmd.device, r_cmd.sector};
    assign tag_hit   = r_cmp_vld && r_valid[r_cmp_idx] && (ram_rdata == ram_wdata);

    scc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_vic),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequence one transaction at a time
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_acc       = r_acc;
        n_busy      = r_busy;
        n_busy_cnt  = r_busy_cnt;
        n_dirty_cnt = r_dirty_cnt;
        n_hand      = r_hand;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_vic       = r_vic;
        n_wb        = r_wb;
        n_cmd       = r_cmd;
        n_res       = r_res;
        o_cmd_pop   = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;
        ram_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res            = '0;
                n_res.entry_slot = r_cmd.slot;
                n_state          = S_DONE;
                unique case (r_cmd.op)
                    OP_ACQUIRE: begin
                        n_res.entry_slot = '0;
                        n_idx            = '0;
                        n_cmp_vld        = 1'b0;
                        n_state          = S_LOOK;
                    end
                    OP_RELEASE: begin
                        if (r_cmd.slot_ok && r_busy[s_idx]) begin
                            n_busy[s_idx] = 1'b0;
                            n_busy_cnt    = r_busy_cnt - CNT_ONE;
                        end
                    end
                    OP_MARK_RD: begin
                        if (r_cmd.slot_ok && r_valid[s_idx]) begin
                            n_acc[s_idx] = 1'b1;
                        end
                    end
                    OP_MARK_WR: begin
                        if (r_cmd.slot_ok && r_valid[s_idx]) begin
                            n_acc[s_idx]   = 1'b1;
                            n_dirty[s_idx] = 1'b1;
                            if (!r_dirty[s_idx]) begin
                                n_dirty_cnt = r_dirty_cnt + CNT_ONE;
                            end
                        end
                    end
                    OP_FLUSH: begin
                        n_res.entry_slot = '0;
                        if (r_dirty_cnt == '0) begin
                            n_res.status = ST_NO_DIRTY;
                        end else begin
                            n_idx   = '0;
                            n_state = S_FSCAN;
                        end
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end

            // Stream tags out of the RAM and compare one entry per cycle
            S_LOOK: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
                if (tag_hit) begin
                    n_res.hit        = 1'b1;
                    n_res.entry_slot = cmp_ext[SLOT_W-1:0];
                    if (r_busy[r_cmp_idx]) begin
                        n_res.status = ST_RETRY;
                    end else begin
                        n_busy[r_cmp_idx] = 1'b1;
                        n_acc[r_cmp_idx]  = 1'b1;
                        n_busy_cnt        = r_busy_cnt + CNT_ONE;
                    end
                    n_state = S_DONE;
                end else if (r_cmp_vld && (r_cmp_idx == LAST)) begin
                    if (r_busy_cnt == CNT_FULL) begin
                        n_res.status = ST_ALL_BUSY;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_HAND;
                    end
                end else begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx;
                    if (r_idx != LAST) begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end

            // Step the clock hand: skip busy, give accessed entries a second chance
            S_HAND: begin
                n_hand = hand_next;
                if (!r_busy[r_hand]) begin
                    if (!r_valid[r_hand] || !r_acc[r_hand]) begin
                        n_vic            = r_hand;
                        n_wb             = r_valid[r_hand] && r_dirty[r_hand];
                        ram_re           = 1'b1;
                        ram_raddr        = r_hand;
                        if (r_dirty[r_hand]) begin
                            n_dirty_cnt = r_dirty_cnt - CNT_ONE;
                        end
                        n_valid[r_hand]  = 1'b1;
                        n_dirty[r_hand]  = 1'b0;
                        n_acc[r_hand]    = 1'b1;
                        n_busy[r_hand]   = 1'b1;
                        n_busy_cnt       = r_busy_cnt + CNT_ONE;
                        n_res.entry_slot = hand_ext[SLOT_W-1:0];
                        n_state          = S_VTAG;
                    end else begin
                        n_acc[r_hand] = 1'b0;
                    end
                end
            end

            // Old tag is out of the RAM: report it and retag the victim
            S_VTAG: begin
                ram_we     = 1'b1;
                n_res.fill = 1'b1;
                if (r_wb) begin
                    n_res.writeback    = 1'b1;
                    n_res.evict_device = ram_rdata[TAG_W-1:SEC_W];
                    n_res.evict_sector = ram_rdata[SEC_W-1:0];
                end
                n_state = S_DONE;
            end

            // Find the lowest dirty entry, one per cycle
            S_FSCAN: begin
                if (r_dirty[r_idx]) begin
                    n_dirty[r_idx]   = 1'b0;
                    n_dirty_cnt      = r_dirty_cnt - CNT_ONE;
                    n_res.more_dirty = (r_dirty_cnt != CNT_ONE);
                    n_vic            = r_idx;
                    ram_re           = 1'b1;
                    ram_raddr        = r_idx;
                    n_state          = S_FTAG;
                end else begin
                    n_idx = (r_idx == LAST) ? '0 : r_idx + IW'(1);
                end
            end

            S_FTAG: begin
                n_res.writeback    = 1'b1;
                n_res.entry_slot   = vic_ext[SLOT_W-1:0];
                n_res.evict_device = ram_rdata[TAG_W-1:SEC_W];
                n_res.evict_sector = ram_rdata[SEC_W-1:0];
                n_state            = S_DONE;
            end

            // Hold the result until the output stage takes it
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_vld = (r_state == S_DONE);
    assign o_res     = r_res;

    // Control state and policy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_acc       <= '0;
            r_busy      <= '0;
            r_busy_cnt  <= '0;
            r_dirty_cnt <= '0;
            r_hand      <= '0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_acc       <= n_acc;
            r_busy      <= n_busy;
            r_busy_cnt  <= n_busy_cnt;
            r_dirty_cnt <= n_dirty_cnt;
            r_hand      <= n_hand;
            r_cmp_vld   <= n_cmp_vld;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_vic     <= n_vic;
        r_wb      <= n_wb;
        r_cmd     <= n_cmd;
        r_res     <= n_res;
    end

`ifndef SYNTHESIS
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_busy) == r_busy_cnt)
        else $error("busy count out of step with busy bits");

    a_dirty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_dirty) == r_dirty_cnt)
        else $error("dirty count out of step with dirty bits");

    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_valid) == '0)
        else $error("dirty bit set on an invalid entry");

    a_hand_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HAND) |-> (r_busy_cnt != CNT_FULL))
        else $error("clock hand running with every entry busy");

    a_flush_has_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FSCAN) |-> (r_dirty_cnt != '0))
        else $error("flush scan running with no dirty entry");
`endif

endmodule
